FILE: hw/rtl/ltr_pkg.sv
package ltr_pkg;

  localparam int unsigned CoordBits     = 9;
  localparam int unsigned ImgWidth      = 512;
  localparam int unsigned BytesPerPixel = 4;
  localparam int unsigned AddrBits      = 20;
  localparam int unsigned ColorBits     = 8;
  localparam int unsigned ErrBits       = CoordBits + 2;
  localparam int unsigned OpBits        = 2;
  localparam int unsigned EdgeBits      = 2;
  localparam int unsigned NumVertices   = 3;

  typedef logic [CoordBits-1:0]       coord_t;
  typedef logic signed [ErrBits-1:0]  err_t;
  typedef logic [EdgeBits-1:0]        edge_t;

  typedef enum logic [OpBits-1:0] {
    OpLoadLine = 2'd0,
    OpLoadTri  = 2'd1,
    OpStep     = 2'd2
  } op_e;

  localparam edge_t LineEdges = edge_t'(1);
  localparam edge_t TriEdges  = edge_t'(3);

  typedef struct packed {
    coord_t x;
    coord_t y;
  } vtx_t;

  typedef struct packed {
    logic [ColorBits-1:0] alpha;
    logic [ColorBits-1:0] blue;
    logic [ColorBits-1:0] green;
    logic [ColorBits-1:0] red;
  } color_t;

  typedef struct packed {
    logic   active;
    edge_t  idx;
    coord_t cur_x;
    coord_t cur_y;
    coord_t end_x;
    coord_t end_y;
    coord_t dx;
    coord_t dy;
    logic   neg_x;
    logic   neg_y;
    err_t   err;
  } walk_t;

  typedef struct packed {
    logic                pixel_valid;
    coord_t              pixel_x;
    coord_t              pixel_y;
    logic [AddrBits-1:0] byte_address;
    color_t              color;
    logic                figure_done;
  } pix_t;

  function automatic logic [AddrBits-1:0] pixel_addr(coord_t x, coord_t y);
    logic [31:0] full;
    full = (32'(x) + 32'(y) * 32'(ImgWidth)) * 32'(BytesPerPixel);
    return full[AddrBits-1:0];
  endfunction

  // first edge at or after 'from' below 'count' with nonzero length
  function automatic walk_t seek_edge(vtx_t v0, vtx_t v1, vtx_t v2, edge_t from,
                                      edge_t count);
    vtx_t  va [NumVertices];
    vtx_t  vb [NumVertices];
    walk_t w;
    logic  found;
    va[0] = v0;
    va[1] = v1;
    va[2] = v2;
    vb[0] = v1;
    vb[1] = v2;
    vb[2] = v0;
    w     = '0;
    found = 1'b0;
    for (int i = 0; i < NumVertices; i++) begin
      if (!found && (edge_t'(i) >= from) && (edge_t'(i) < count) && (va[i] != vb[i])) begin
        found    = 1'b1;
        w.active = 1'b1;
        w.idx    = edge_t'(i);
        w.cur_x  = va[i].x;
        w.cur_y  = va[i].y;
        w.end_x  = vb[i].x;
        w.end_y  = vb[i].y;
        w.dx     = (vb[i].x > va[i].x) ? vb[i].x - va[i].x : va[i].x - vb[i].x;
        w.dy     = (vb[i].y > va[i].y) ? vb[i].y - va[i].y : va[i].y - vb[i].y;
        w.neg_x  = !(va[i].x < vb[i].x);
        w.neg_y  = !(va[i].y < vb[i].y);
        w.err    = err_t'({2'b00, w.dx}) - err_t'({2'b00, w.dy});
      end
    end
    return w;
  endfunction

endpackage

FILE: hw/rtl/ltr_item_if.sv
interface ltr_item_if;
  logic                                        valid;
  logic                                        ready;
  logic [ltr_pkg::OpBits-1:0]                  opcode;
  ltr_pkg::coord_t                             x_a;
  ltr_pkg::coord_t                             y_a;
  ltr_pkg::coord_t                             x_b;
  ltr_pkg::coord_t                             y_b;
  ltr_pkg::coord_t                             x_c;
  ltr_pkg::coord_t                             y_c;
  logic [ltr_pkg::ColorBits-1:0]               red;
  logic [ltr_pkg::ColorBits-1:0]               green;
  logic [ltr_pkg::ColorBits-1:0]               blue;
  logic [ltr_pkg::ColorBits-1:0]               alpha;

  modport source (
    output valid, opcode, x_a, y_a, x_b, y_b, x_c, y_c, red, green, blue, alpha,
    input  ready
  );
  modport sink (
    input  valid, opcode, x_a, y_a, x_b, y_b, x_c, y_c, red, green, blue, alpha,
    output ready
  );
endinterface

FILE: hw/rtl/ltr_pixel_if.sv
interface ltr_pixel_if;
  logic                               valid;
  logic                               ready;
  logic                               pixel_valid;
  ltr_pkg::coord_t                    pixel_x;
  ltr_pkg::coord_t                    pixel_y;
  logic [ltr_pkg::AddrBits-1:0]       byte_address;
  logic [ltr_pkg::ColorBits-1:0]      out_red;
  logic [ltr_pkg::ColorBits-1:0]      out_green;
  logic [ltr_pkg::ColorBits-1:0]      out_blue;
  logic [ltr_pkg::ColorBits-1:0]      out_alpha;
  logic                               figure_done;

  modport source (
    output valid, pixel_valid, pixel_x, pixel_y, byte_address, out_red, out_green,
           out_blue, out_alpha, figure_done,
    input  ready
  );
  modport sink (
    input  valid, pixel_valid, pixel_x, pixel_y, byte_address, out_red, out_green,
           out_blue, out_alpha, figure_done,
    output ready
  );
endinterface

FILE: hw/rtl/line_triangle_rasterizer.sv
// Bresenham walker for lines and triangle outlines, all octants.
// item_i takes command words: load line (vertices a, b), load triangle
// (a, b, c, walked a->b, b->c, c->a) or step. Every command word gives exactly
// one result word on pixel_o. A step returns the next pixel with its
// framebuffer byte address and color; figure_done marks the last one. Loads
// and steps while idle return a word with pixel_valid low. Segment end points
// are not drawn and zero-length edges are skipped.
// An accepted word's result is registered in the head entry (on pixel_o) or,
// while the head word waits, in the skid entry. Throughput: one word per clock
// while ready is high; error add/compare and next-edge setup are combinational.
// The result side has a two-entry buffer, so a word is still accepted while
// one result waits; item_i.ready drops only when both entries are full, and
// comes back the cycle after the receiver takes a word.
// Reset (rst_ni low, asynchronous) empties the buffer and leaves the walker
// idle with zero color; vertex storage is not cleared since every load
// rewrites all three vertices.
module line_triangle_rasterizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  ltr_item_if.sink    item_i,
  ltr_pixel_if.source pixel_o
);

  ltr_pkg::vtx_t   vtx_q [ltr_pkg::NumVertices];
  ltr_pkg::color_t color_q;
  ltr_pkg::walk_t  walk_q, walk_d;
  ltr_pkg::edge_t  count_q, count_d;

  ltr_pkg::pix_t   head_q, skid_q, res;
  logic            head_valid_q, head_valid_d;
  logic            skid_valid_q, skid_valid_d;
  logic            head_load, head_from_skid, skid_load;

  ltr_pkg::op_e    op;
  logic            acc, take, is_load, arrived;
  ltr_pkg::vtx_t   in_va, in_vb, in_vc;
  ltr_pkg::color_t in_color;
  ltr_pkg::walk_t  adv;

  logic signed [ltr_pkg::ErrBits:0] e2, dx_s, dy_s, err_n;
  logic                             move_x, move_y;

  assign item_i.ready = !skid_valid_q;
  assign acc          = item_i.valid && item_i.ready;
  assign take         = head_valid_q && pixel_o.ready;
  assign op           = ltr_pkg::op_e'(item_i.opcode);
  assign is_load      = (op == ltr_pkg::OpLoadLine) || (op == ltr_pkg::OpLoadTri);

  assign in_va    = '{x: item_i.x_a, y: item_i.y_a};
  assign in_vb    = '{x: item_i.x_b, y: item_i.y_b};
  assign in_vc    = '{x: item_i.x_c, y: item_i.y_c};
  assign in_color = '{alpha: item_i.alpha, blue: item_i.blue, green: item_i.green,
                      red: item_i.red};

  // one bresenham step from the current walk state
  always_comb begin
    e2     = {walk_q.err, 1'b0};
    dx_s   = $signed({3'b000, walk_q.dx});
    dy_s   = $signed({3'b000, walk_q.dy});
    move_x = e2 > -dy_s;
    move_y = e2 < dx_s;
    err_n  = {walk_q.err[ltr_pkg::ErrBits-1], walk_q.err};
    if (move_x) begin
      err_n = err_n - dy_s;
    end
    if (move_y) begin
      err_n = err_n + dx_s;
    end
    adv     = walk_q;
    adv.err = err_n[ltr_pkg::ErrBits-1:0];
    if (move_x) begin
      adv.cur_x = walk_q.neg_x ? walk_q.cur_x - 1'b1 : walk_q.cur_x + 1'b1;
    end
    if (move_y) begin
      adv.cur_y = walk_q.neg_y ? walk_q.cur_y - 1'b1 : walk_q.cur_y + 1'b1;
    end
    arrived = (adv.cur_x == walk_q.end_x) && (adv.cur_y == walk_q.end_y);
  end

  always_comb begin
    walk_d  = walk_q;
    count_d = count_q;
    res     = '0;
    unique case (op)
      ltr_pkg::OpLoadLine, ltr_pkg::OpLoadTri: begin
        count_d = (op == ltr_pkg::OpLoadLine) ? ltr_pkg::LineEdges : ltr_pkg::TriEdges;
        walk_d  = ltr_pkg::seek_edge(in_va, in_vb, in_vc, '0, count_d);
        res.figure_done = !walk_d.active;
      end
      ltr_pkg::OpStep: begin
        if (walk_q.active) begin
          res.pixel_valid  = 1'b1;
          res.pixel_x      = walk_q.cur_x;
          res.pixel_y      = walk_q.cur_y;
          res.byte_address = ltr_pkg::pixel_addr(walk_q.cur_x, walk_q.cur_y);
          res.color        = color_q;
          if (arrived) begin
            walk_d = ltr_pkg::seek_edge(vtx_q[0], vtx_q[1], vtx_q[2],
                                        walk_q.idx + 1'b1, count_q);
          end else begin
            walk_d = adv;
          end
          res.figure_done = !walk_d.active;
        end else begin
          res.figure_done = 1'b1;
        end
      end
      default: begin
        res.figure_done = !walk_q.active;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_q  <= '0;
      count_q <= '0;
      color_q <= '0;
    end else if (acc) begin
      walk_q  <= walk_d;
      count_q <= count_d;
      if (is_load) begin
        color_q <= in_color;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && is_load) begin
      vtx_q[0] <= in_va;
      vtx_q[1] <= in_vb;
      vtx_q[2] <= in_vc;
    end
  end

  // two-entry result buffer: head drives the port, skid catches a word on stall
  always_comb begin
    head_load      = acc && (!head_valid_q || take);
    skid_load      = acc && head_valid_q && !take;
    head_from_skid = !acc && take && skid_valid_q;
    head_valid_d   = head_valid_q;
    skid_valid_d   = skid_valid_q;
    if (head_load || head_from_skid) begin
      head_valid_d = 1'b1;
    end else if (take) begin
      head_valid_d = 1'b0;
    end
    if (skid_load) begin
      skid_valid_d = 1'b1;
    end else if (head_from_skid) begin
      skid_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      head_valid_q <= head_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (head_load) begin
      head_q <= res;
    end else if (head_from_skid) begin
      head_q <= skid_q;
    end
    if (skid_load) begin
      skid_q <= res;
    end
  end

  assign pixel_o.valid        = head_valid_q;
  assign pixel_o.pixel_valid  = head_q.pixel_valid;
  assign pixel_o.pixel_x      = head_q.pixel_x;
  assign pixel_o.pixel_y      = head_q.pixel_y;
  assign pixel_o.byte_address = head_q.byte_address;
  assign pixel_o.out_red      = head_q.color.red;
  assign pixel_o.out_green    = head_q.color.green;
  assign pixel_o.out_blue     = head_q.color.blue;
  assign pixel_o.out_alpha    = head_q.color.alpha;
  assign pixel_o.figure_done  = head_q.figure_done;

endmodule

FILE: tb/ltr_rasterizer_checker.sv
`timescale 1ns / 100ps

module ltr_rasterizer_checker
  import ltr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  ltr_item_if         item_i,
  ltr_pixel_if        pixel_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned pixels_o,
  output int unsigned figures_o
);

  // walker copy
  coord_t walk_x, walk_y, stop_x, stop_y, span_x, span_y;
  logic   dir_neg_x, dir_neg_y;
  err_t   walk_err;
  vtx_t   corners [NumVertices];
  edge_t  seg_idx, seg_total;
  color_t pen_color;
  logic   drawing;

  pix_t   pending_pixels [$];
  pix_t   want, got;

  // set up the first edge at or after 'from' that has nonzero length
  task automatic start_segment(input int from);
    vtx_t p, q;
    drawing = 1'b0;
    for (int i = from; i < int'(seg_total) && i < int'(NumVertices) && !drawing; i++) begin
      p = corners[i];
      q = corners[(i + 1) % NumVertices];
      if (p != q) begin
        walk_x    = p.x;
        walk_y    = p.y;
        stop_x    = q.x;
        stop_y    = q.y;
        span_x    = (q.x > p.x) ? q.x - p.x : p.x - q.x;
        span_y    = (q.y > p.y) ? q.y - p.y : p.y - q.y;
        dir_neg_x = !(p.x < q.x);
        dir_neg_y = !(p.y < q.y);
        walk_err  = err_t'(int'(span_x) - int'(span_y));
        seg_idx   = edge_t'(i);
        drawing   = 1'b1;
      end
    end
  endtask

  task automatic rasterize_word(input logic [OpBits-1:0] op, input vtx_t a, input vtx_t b,
                                input vtx_t c, input color_t col, output pix_t res);
    int          e2;
    logic [31:0] addr_full;
    res = '0;
    case (op)
      OpLoadLine, OpLoadTri: begin
        corners[0] = a;
        corners[1] = b;
        corners[2] = c;
        pen_color  = col;
        seg_total  = (op == OpLoadLine) ? LineEdges : TriEdges;
        start_segment(0);
        res.figure_done = !drawing;
      end
      OpStep: begin
        if (!drawing) begin
          res.figure_done = 1'b1;
        end else begin
          res.pixel_valid  = 1'b1;
          res.pixel_x      = walk_x;
          res.pixel_y      = walk_y;
          addr_full        = (32'(walk_x) + 32'(walk_y) * ImgWidth) * BytesPerPixel;
          res.byte_address = addr_full[AddrBits-1:0];
          res.color        = pen_color;
          // both moves use the error term from before this step
          e2 = 2 * int'(walk_err);
          if (e2 > -int'(span_y)) begin
            walk_err = err_t'(int'(walk_err) - int'(span_y));
            walk_x   = dir_neg_x ? walk_x - 1'b1 : walk_x + 1'b1;
          end
          if (e2 < int'(span_x)) begin
            walk_err = err_t'(int'(walk_err) + int'(span_x));
            walk_y   = dir_neg_y ? walk_y - 1'b1 : walk_y + 1'b1;
          end
          if (walk_x == stop_x && walk_y == stop_y) begin
            start_segment(int'(seg_idx) + 1);
          end
          res.figure_done = !drawing;
          if (!drawing) figures_o++;
        end
      end
      default: begin
        res.figure_done = !drawing;
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: pixel word field %s mismatch, expected %0h, actual %0h",
               $time, name, want_v, got_v);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_x    = '0;
      walk_y    = '0;
      stop_x    = '0;
      stop_y    = '0;
      span_x    = '0;
      span_y    = '0;
      dir_neg_x = 1'b0;
      dir_neg_y = 1'b0;
      walk_err  = '0;
      seg_idx   = '0;
      seg_total = '0;
      pen_color = '0;
      drawing   = 1'b0;
      pending_pixels.delete();
      pending_o    = 0;
      fail_count_o = 0;
      pixels_o     = 0;
      figures_o    = 0;
    end else begin
      if (pixel_i.valid && pixel_i.ready) begin
        if (pending_pixels.size() == 0) begin
          $display("%0t: unexpected pixel word, expected none, actual x=%0d y=%0d valid=%0b",
                   $time, pixel_i.pixel_x, pixel_i.pixel_y, pixel_i.pixel_valid);
          fail_count_o++;
        end else begin
          want = pending_pixels.pop_front();
          check_field("pixel_valid", 32'(want.pixel_valid), 32'(pixel_i.pixel_valid));
          check_field("pixel_x", 32'(want.pixel_x), 32'(pixel_i.pixel_x));
          check_field("pixel_y", 32'(want.pixel_y), 32'(pixel_i.pixel_y));
          check_field("byte_address", 32'(want.byte_address), 32'(pixel_i.byte_address));
          check_field("out_red", 32'(want.color.red), 32'(pixel_i.out_red));
          check_field("out_green", 32'(want.color.green), 32'(pixel_i.out_green));
          check_field("out_blue", 32'(want.color.blue), 32'(pixel_i.out_blue));
          check_field("out_alpha", 32'(want.color.alpha), 32'(pixel_i.out_alpha));
          check_field("figure_done", 32'(want.figure_done), 32'(pixel_i.figure_done));
          if (want.pixel_valid) pixels_o++;
        end
      end
      if (item_i.valid && item_i.ready) begin
        rasterize_word(item_i.opcode, '{x: item_i.x_a, y: item_i.y_a},
                       '{x: item_i.x_b, y: item_i.y_b}, '{x: item_i.x_c, y: item_i.y_c},
                       '{alpha: item_i.alpha, blue: item_i.blue, green: item_i.green,
                         red: item_i.red}, got);
        pending_pixels.push_back(got);
      end
      pending_o = pending_pixels.size();
    end
  end

endmodule

FILE: tb/line_triangle_rasterizer_tb.sv
`timescale 1ns / 100ps

module line_triangle_rasterizer_tb;
  import ltr_pkg::*;

  localparam logic [OpBits-1:0] OpUnused   = 2'd3;
  localparam int unsigned       HoldCycles = 300;
  localparam int unsigned       DrainLimit = 20000;
  localparam int unsigned       PhaseWords = 120;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  ltr_item_if  item_if ();
  ltr_pixel_if pixel_if ();

  int unsigned fail_count, pending, pixels, figures;
  int unsigned words_sent     = 0;
  int unsigned directed_words = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct  = 0;
  int unsigned hold_requests   = 0;
  int unsigned holds_done      = 0;
  int unsigned drain_cycles;

  line_triangle_rasterizer i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_if),
    .pixel_o (pixel_if)
  );

  ltr_rasterizer_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item_if),
    .pixel_i      (pixel_if),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .pixels_o     (pixels),
    .figures_o    (figures)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("line_triangle_rasterizer_tb failed");
    $finish;
  end

  // receiver: random stalls, plus a long hold-off on request
  always begin
    @(posedge clk_i);
    if (!rst_ni) begin
      pixel_if.ready <= 1'b0;
    end else if (hold_requests != holds_done) begin
      pixel_if.ready <= 1'b0;
      repeat (HoldCycles - 1) @(posedge clk_i);
      holds_done++;
    end else begin
      pixel_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic vtx_t vtx(input int x, input int y);
    vtx_t v;
    v.x = coord_t'(x);
    v.y = coord_t'(y);
    return v;
  endfunction

  function automatic vtx_t random_vtx();
    vtx_t v;
    v.x = coord_t'($urandom);
    v.y = coord_t'($urandom);
    return v;
  endfunction

  function automatic int clamp_coord(input int v);
    if (v < 0) return 0;
    if (v > 511) return 511;
    return v;
  endfunction

  function automatic vtx_t near(input vtx_t o, input int span);
    int nx, ny;
    nx = int'(o.x) + int'($urandom_range(2 * span)) - span;
    ny = int'(o.y) + int'($urandom_range(2 * span)) - span;
    return vtx(clamp_coord(nx), clamp_coord(ny));
  endfunction

  // pixels on one edge: the walk takes one step per major-axis unit
  function automatic int seg_len(input vtx_t p, input vtx_t q);
    int dx, dy;
    dx = (p.x > q.x) ? int'(p.x) - int'(q.x) : int'(q.x) - int'(p.x);
    dy = (p.y > q.y) ? int'(p.y) - int'(q.y) : int'(q.y) - int'(p.y);
    return (dx > dy) ? dx : dy;
  endfunction

  // called at a rising edge, returns at the edge where the word is taken
  task automatic send_word(input logic [OpBits-1:0] op, input vtx_t a, input vtx_t b,
                           input vtx_t c, input color_t col);
    if ($urandom_range(99) < sender_idle_pct) begin
      item_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
    item_if.valid  <= 1'b1;
    item_if.opcode <= op;
    item_if.x_a    <= a.x;
    item_if.y_a    <= a.y;
    item_if.x_b    <= b.x;
    item_if.y_b    <= b.y;
    item_if.x_c    <= c.x;
    item_if.y_c    <= c.y;
    item_if.red    <= col.red;
    item_if.green  <= col.green;
    item_if.blue   <= col.blue;
    item_if.alpha  <= col.alpha;
    @(negedge clk_i);
    while (!item_if.ready) begin
      @(posedge clk_i);
      @(negedge clk_i);
    end
    @(posedge clk_i);
    words_sent++;
  endtask

  task automatic send_steps(input int n);
    for (int i = 0; i < n; i++) begin
      send_word(OpStep, random_vtx(), random_vtx(), random_vtx(), color_t'($urandom));
    end
  endtask

  // mostly a load followed by the steps that finish it, sometimes cut short or noise
  task automatic random_figure();
    int unsigned       pick, span, steps;
    int                pixel_total;
    vtx_t              v [3];
    logic [OpBits-1:0] op;
    pick = $urandom_range(99);
    if (pick < 12) begin
      send_word(OpBits'($urandom_range(3)), random_vtx(), random_vtx(), random_vtx(),
                color_t'($urandom));
    end else begin
      span = (pick < 16) ? 60 : ((pick < 35) ? 20 : 6);
      v[0] = random_vtx();
      v[1] = near(v[0], span);
      v[2] = near(v[0], span);
      if ($urandom_range(9) == 0) v[1] = v[0];
      else if ($urandom_range(9) == 0) v[2] = v[1];
      op = ($urandom_range(1) == 1 && span != 60) ? OpLoadTri : OpLoadLine;
      pixel_total = seg_len(v[0], v[1]);
      if (op == OpLoadTri) pixel_total += seg_len(v[1], v[2]) + seg_len(v[2], v[0]);
      steps = ($urandom_range(99) < 15) ? $urandom_range(pixel_total)
                                        : pixel_total + $urandom_range(2);
      send_word(op, v[0], v[1], v[2], color_t'($urandom));
      for (int i = 0; i < steps; i++) begin
        if ($urandom_range(99) < 3) begin
          send_word(OpUnused, random_vtx(), random_vtx(), random_vtx(), color_t'($urandom));
        end
        send_steps(1);
      end
    end
  endtask

  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                           input bit hold_off);
    int unsigned start;
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
    if (hold_off) hold_requests++;
    start = words_sent;
    while (words_sent - start < PhaseWords) random_figure();
  endtask

  initial begin
    item_if.valid  = 1'b0;
    item_if.opcode = '0;
    item_if.x_a    = '0;
    item_if.y_a    = '0;
    item_if.x_b    = '0;
    item_if.y_b    = '0;
    item_if.x_c    = '0;
    item_if.y_c    = '0;
    item_if.red    = '0;
    item_if.green  = '0;
    item_if.blue   = '0;
    item_if.alpha  = '0;
    rst_ni         = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: idle commands, empty figures, extreme corners, reload mid-figure
    send_word(OpStep, vtx(0, 0), vtx(0, 0), vtx(0, 0), color_t'(32'h0));
    send_word(OpUnused, vtx(511, 511), vtx(511, 511), vtx(511, 511), color_t'(32'hffffffff));
    send_word(OpLoadLine, vtx(0, 0), vtx(0, 0), vtx(511, 511), color_t'(32'hffffffff));
    send_word(OpLoadLine, vtx(511, 511), vtx(509, 510), vtx(0, 0), color_t'(32'hffffffff));
    send_steps(3);
    send_word(OpLoadTri, vtx(0, 0), vtx(2, 0), vtx(0, 2), color_t'(32'h00000000));
    send_word(OpUnused, vtx(0, 0), vtx(0, 0), vtx(0, 0), color_t'(32'h0));
    send_steps(6);
    send_word(OpLoadTri, vtx(5, 5), vtx(5, 5), vtx(7, 9), color_t'(32'h5aa50ff0));
    send_steps(2);
    // line folded back on itself, reloaded before it ends
    send_word(OpLoadTri, vtx(0, 511), vtx(1, 505), vtx(0, 511), color_t'(32'ha55af00f));
    send_steps(3);
    send_word(OpLoadTri, vtx(9, 9), vtx(9, 9), vtx(9, 9), color_t'(32'h12345678));
    send_word(OpLoadLine, vtx(511, 0), vtx(0, 511), vtx(511, 0), color_t'(32'h80808080));
    send_steps(2);
    directed_words = words_sent;

    run_phase(0, 0, 1'b0);
    run_phase(45, 0, 1'b0);
    run_phase(0, 45, 1'b0);
    run_phase(30, 30, 1'b0);
    run_phase(0, 0, 1'b1);
    item_if.valid <= 1'b0;

    // let the checker see the last accepted word before looking at the backlog
    @(negedge clk_i);
    drain_cycles = 0;
    while (pending != 0 && drain_cycles < DrainLimit) begin
      @(negedge clk_i);
      drain_cycles++;
    end
    if (pending != 0) begin
      $display("%0t: %0d pixel words never arrived", $time, pending);
      $display("line_triangle_rasterizer_tb failed");
    end else begin
      repeat (5) @(negedge clk_i);
      $display("summary: %0d command words (%0d directed), %0d pixels, %0d figures drawn out",
               words_sent, directed_words, pixels, figures);
      $display("summary: no idling, sender gaps, receiver stalls, both, %0d-cycle hold-off",
               HoldCycles);
      if (fail_count == 0) begin
        $display("line_triangle_rasterizer_tb passed");
      end else begin
        $display("line_triangle_rasterizer_tb failed");
      end
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/ltr_pkg.sv
hw/rtl/ltr_item_if.sv
hw/rtl/ltr_pixel_if.sv
hw/rtl/line_triangle_rasterizer.sv
tb/ltr_rasterizer_checker.sv
tb/line_triangle_rasterizer_tb.sv
